// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker module of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tbt_pkg.sv =====
// Shared types and constants of the trailing blank line trimmer.
// No dependencies; used by all modules through scoped names.
package tbt_pkg;

  // Depth of the held-blank buffer and derived widths
  localparam int PENDING_DEPTH = 32;
  localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
  localparam int KIDX_W        = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  // Command queue between front and back
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Blank kind codes
  localparam logic KIND_SPACE = 1'b0;
  localparam logic KIND_TAB   = 1'b1;

  // One command: replay cnt held blanks from kinds, then emit ch as last
  typedef struct packed {
    logic [PENDING_DEPTH-1:0] kinds;
    logic [CNT_W-1:0]         cnt;
    logic [7:0]               ch;
    logic                     ovf;
  } cmd_t;

  // Front to queue write request
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_req_t;

  // Queue to back status
  typedef struct packed {
    logic valid;
    cmd_t head;
  } cmd_head_t;

endpackage

// ===== rtl/tbt_front.sv =====
// Front end: accepts bytes, holds blanks, and turns content bytes and line
// ends after content into replay commands. Depends on tbt_pkg.
module tbt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [7:0]          in_char,
  input  logic                in_end_of_input,
  input  logic                fifo_full,
  output logic                in_full,
  output tbt_pkg::cmd_req_t   req
);

  logic [tbt_pkg::PENDING_DEPTH-1:0] kind_r, kind_nxt;
  logic [tbt_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                              content_r, content_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              accept;
  logic                              is_eol;
  logic                              is_blank;

  assign in_full = fifo_full;
  assign accept  = in_push && !fifo_full;
  assign is_eol  = in_end_of_input || (in_char == tbt_pkg::CH_NEWLINE);
  assign is_blank = (in_char == tbt_pkg::CH_SPACE) || (in_char == tbt_pkg::CH_TAB);

  // Classify the item and update line state
  always_comb begin
    kind_nxt     = kind_r;
    cnt_nxt      = cnt_r;
    content_nxt  = content_r;
    ovf_nxt      = ovf_r;
    req.push      = 1'b0;
    req.cmd.kinds = kind_r;
    req.cmd.cnt   = cnt_r;
    req.cmd.ch    = in_char;
    req.cmd.ovf   = ovf_r;
    if (accept) begin
      if (is_eol) begin
        // line end: newline only if the line had content
        req.push     = content_r;
        req.cmd.cnt  = '0;
        req.cmd.ch   = tbt_pkg::CH_NEWLINE;
        cnt_nxt      = '0;
        content_nxt  = 1'b0;
        ovf_nxt      = 1'b0;
      end else if (is_blank) begin
        if (cnt_r < tbt_pkg::CNT_W'(tbt_pkg::PENDING_DEPTH)) begin
          kind_nxt[cnt_r[tbt_pkg::KIDX_W-1:0]] =
            (in_char == tbt_pkg::CH_TAB) ? tbt_pkg::KIND_TAB : tbt_pkg::KIND_SPACE;
          cnt_nxt = cnt_r + tbt_pkg::CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else begin
        // content byte: replay held blanks, then the byte
        req.push    = 1'b1;
        cnt_nxt     = '0;
        content_nxt = 1'b1;
      end
    end
  end

  // Held blank kinds carry no reset; only written entries are read
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      content_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      content_r <= content_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

// ===== rtl/tbt_cmd_fifo.sv =====
// Short command queue that decouples the front end from the replay back end.
// Depends on tbt_pkg.
module tbt_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbt_pkg::cmd_req_t    req,
  input  logic                 pop,
  output logic                 full,
  output tbt_pkg::cmd_head_t   head
);

  tbt_pkg::cmd_t                 mem_r [tbt_pkg::FIFO_DEPTH];
  logic [tbt_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tbt_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tbt_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (cnt_r == tbt_pkg::FIFO_CNT_W'(tbt_pkg::FIFO_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.head  = mem_r[rd_ptr_r];
  assign do_push    = req.push && !full;
  assign do_pop     = pop && head.valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == tbt_pkg::FIFO_PTR_W'(tbt_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + tbt_pkg::FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == tbt_pkg::FIFO_PTR_W'(tbt_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + tbt_pkg::FIFO_PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + tbt_pkg::FIFO_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - tbt_pkg::FIFO_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/tbt_back.sv =====
// Back end: replays held blanks of the head command, then its byte, into an
// output register. Depends on tbt_pkg.
module tbt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbt_pkg::cmd_head_t   head,
  input  logic                 out_pop,
  output logic                 q_pop,
  output logic                 out_empty,
  output logic [7:0]           out_char,
  output logic                 out_last,
  output logic                 out_blanks_dropped
);

  logic [tbt_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic [7:0]                ochar_r, ochar_nxt;
  logic                      olast_r, olast_nxt;
  logic                      odrop_r, odrop_nxt;
  logic                      slot_free;
  logic                      emit;
  logic                      in_blanks;

  assign slot_free = !ovalid_r || out_pop;
  assign emit      = head.valid && slot_free;
  assign in_blanks = (idx_r != head.head.cnt);
  assign q_pop     = emit && !in_blanks;

  // Replay sequencer: one result per cycle while the output slot is free
  always_comb begin
    idx_nxt    = idx_r;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    odrop_nxt  = odrop_r;
    ovalid_nxt = ovalid_r && !out_pop;
    if (emit) begin
      ovalid_nxt = 1'b1;
      odrop_nxt  = head.head.ovf;
      if (in_blanks) begin
        ochar_nxt = (head.head.kinds[idx_r[tbt_pkg::KIDX_W-1:0]] == tbt_pkg::KIND_TAB) ?
                    tbt_pkg::CH_TAB : tbt_pkg::CH_SPACE;
        olast_nxt = 1'b0;
        idx_nxt   = idx_r + tbt_pkg::CNT_W'(1);
      end else begin
        ochar_nxt = head.head.ch;
        olast_nxt = 1'b1;
        idx_nxt   = '0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    odrop_r <= odrop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_empty          = !ovalid_r;
  assign out_char           = ochar_r;
  assign out_last           = olast_r;
  assign out_blanks_dropped = odrop_r;

endmodule

// ===== rtl/trailing_blank_line_trimmer_top.sv =====
// Trailing blank line trimmer, top level. Depends on tbt_pkg, tbt_front,
// tbt_cmd_fifo and tbt_back.
//
// Removes trailing spaces/tabs and blank lines from a byte stream. One input
// byte is accepted per cycle while in_full is low. Blanks are held in a
// 32-entry buffer (extra blanks on a line are dropped and flagged); a content
// byte or a line end after content becomes a command in a 2-entry queue. The
// back end emits one result per cycle while its output slot is free, so a
// content byte preceded by n held blanks yields n+1 results; in_full rises
// when the queue holds two commands not yet fully emitted. The first result
// of an item passes through the queue and the output register to the ports.
module trailing_blank_line_trimmer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char,
  input  logic       in_end_of_input,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_blanks_dropped
);

  tbt_pkg::cmd_req_t  req;
  tbt_pkg::cmd_head_t head;
  logic               fifo_full;
  logic               q_pop;

  tbt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_char         (in_char),
    .in_end_of_input (in_end_of_input),
    .fifo_full       (fifo_full),
    .in_full         (in_full),
    .req             (req)
  );

  tbt_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .pop   (q_pop),
    .full  (fifo_full),
    .head  (head)
  );

  tbt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .out_pop            (out_pop),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_char           (out_char),
    .out_last           (out_last),
    .out_blanks_dropped (out_blanks_dropped)
  );

endmodule

// ===== rtl/tbt_checker.sv =====
// Port-level checker for the trailing blank line trimmer, with its bind.
// Depends on tbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       out_blanks_dropped
);

  // Both sides come out of reset idle
  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (out_empty && !in_full), "not idle after reset")

  // A waiting result holds until taken
  `ASSERT_CLK(a_out_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_char) && $stable(out_last) && $stable(out_blanks_dropped)), "result changed while waiting")

  // Newlines always close a result group
  `ASSERT_CLK(a_nl_last, (!out_empty && out_char == tbt_pkg::CH_NEWLINE) |-> out_last, "newline not marked last")

  // Only replayed blanks are non-final results
  `ASSERT_CLK(a_mid_blank, (!out_empty && !out_last) |-> (out_char == tbt_pkg::CH_SPACE || out_char == tbt_pkg::CH_TAB), "non-final result is not a blank")

endmodule

bind trailing_blank_line_trimmer_top tbt_checker u_tbt_checker (.*);
